>>> sv/fcr_pkg.sv
// Package for the fixed-frame CRC8 receiver: frame layout constants,
// opcodes, status codes, the result type and the byte-wide CRC8 update.
// No dependencies.
package fcr_pkg;

    localparam int PAYLOAD_BYTES = 32;
    localparam int CRC_POS       = PAYLOAD_BYTES + 8;
    localparam int POS_W         = $clog2(CRC_POS + 1);

    localparam logic [7:0] CRC_POLY    = 8'hD5;
    localparam logic [7:0] START_CHAR  = 8'h24;
    localparam logic [7:0] HEADER_CHAR = 8'h58;
    localparam logic [7:0] TYPE_CHAR   = 8'h3E;

    localparam logic [POS_W-1:0] POS_START  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HEADER = POS_W'(1);
    localparam logic [POS_W-1:0] POS_TYPE   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_FUNC_L = POS_W'(4);
    localparam logic [POS_W-1:0] POS_FUNC_H = POS_W'(5);
    localparam logic [POS_W-1:0] POS_SIZE_L = POS_W'(6);
    localparam logic [POS_W-1:0] POS_SIZE_H = POS_W'(7);
    localparam logic [POS_W-1:0] POS_CRC    = POS_W'(CRC_POS);

    typedef enum logic {
        OP_RX_BYTE    = 1'b0,
        OP_LINK_CHECK = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_BAD_HDR = 2'd1,
        ST_BAD_CRC = 2'd2
    } status_t;

    typedef struct packed {
        logic        frame_done;
        logic [1:0]  frame_status;
        logic [15:0] function_code;
        logic [15:0] payload_length;
        logic        link_ok;
        logic [15:0] good_frames;
    } result_t;

    // MSB-first CRC8 over one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7])
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            else
                v = {v[6:0], 1'b0};
        end
        return v;
    endfunction

endpackage

>>> sv/fcr_if.sv
// Valid/ready channel interfaces for the fixed-frame CRC8 receiver:
// fcr_item_if carries input beats, fcr_result_if carries result beats.
// Depends on nothing but the port types they declare.
interface fcr_item_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface fcr_result_if;
    logic        valid;
    logic        ready;
    logic        frame_done;
    logic [1:0]  frame_status;
    logic [15:0] function_code;
    logic [15:0] payload_length;
    logic        link_ok;
    logic [15:0] good_frames;

    modport source (output valid, output frame_done, output frame_status,
                    output function_code, output payload_length,
                    output link_ok, output good_frames, input ready);
    modport sink   (input valid, input frame_done, input frame_status,
                    input function_code, input payload_length,
                    input link_ok, input good_frames, output ready);
endinterface

>>> sv/fixed_frame_crc8_receiver.sv
// Fixed-frame CRC8 receiver: one item per beat, frame state and result register.
// A result is registered and shown in the cycle after its item is accepted.
// Throughput: one item per cycle; the single result register is refilled in the
// same cycle it is taken, so input ready follows result ready.
// Reset (rst_n low, async): frame position 0, CRC 0, header flag set, latches and
// good-frame count 0, minimum 1, result register empty.
module fixed_frame_crc8_receiver (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    fcr_item_if.sink     item,
    fcr_result_if.source result
);
    import fcr_pkg::*;

    logic [15:0]      min_good_reg;
    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [7:0]       crc_reg,  crc_next;
    logic             hdr_reg,  hdr_next;
    logic [15:0]      func_reg, func_next;
    logic [15:0]      size_reg, size_next;
    logic [15:0]      count_reg, count_next;
    logic             out_valid_reg;
    result_t          out_reg, out_next;
    logic             take;
    status_t          status;

    assign item.ready = !out_valid_reg || result.ready;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        hdr_next   = hdr_reg;
        func_next  = func_reg;
        size_next  = size_reg;
        count_next = count_reg;
        out_next   = '0;
        status     = ST_VALID;

        if (item.opcode == OP_LINK_CHECK) begin
            out_next.good_frames = count_reg;
            if (count_reg >= min_good_reg) begin
                out_next.link_ok = 1'b1;
                count_next       = '0;
            end
        end else begin
            case (pos_reg)
                POS_START:  hdr_next = (item.rx_byte == START_CHAR);
                POS_HEADER: hdr_next = hdr_reg && (item.rx_byte == HEADER_CHAR);
                POS_TYPE:   hdr_next = hdr_reg && (item.rx_byte == TYPE_CHAR);
                POS_FUNC_L: func_next[7:0]  = item.rx_byte;
                POS_FUNC_H: func_next[15:8] = item.rx_byte;
                POS_SIZE_L: size_next[7:0]  = item.rx_byte;
                POS_SIZE_H: size_next[15:8] = item.rx_byte;
                default:    ;
            endcase

            if (pos_reg >= POS_CRC) begin
                // header flag here is the one built over bytes 0 to 2
                if (!hdr_reg)
                    status = ST_BAD_HDR;
                else if (crc_reg != item.rx_byte)
                    status = ST_BAD_CRC;
                if (status == ST_VALID && count_reg != 16'hFFFF)
                    count_next = count_reg + 16'd1;
                out_next.frame_done     = 1'b1;
                out_next.frame_status   = status;
                out_next.function_code  = func_reg;
                out_next.payload_length = size_reg;
                pos_next                = '0;
            end else begin
                if (pos_reg == POS_START)
                    crc_next = '0;
                else if (pos_reg >= POS_TYPE)
                    crc_next = crc8_byte(crc_reg, item.rx_byte);
                pos_next = pos_reg + POS_W'(1);
            end
            out_next.good_frames = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            min_good_reg  <= 16'd1;
            pos_reg       <= '0;
            crc_reg       <= '0;
            hdr_reg       <= 1'b1;
            func_reg      <= '0;
            size_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en)
                min_good_reg <= cfg_wr_data;
            if (take) begin
                pos_reg   <= pos_next;
                crc_reg   <= crc_next;
                hdr_reg   <= hdr_next;
                func_reg  <= func_next;
                size_reg  <= size_next;
                count_reg <= count_next;
            end
            // hold the result until taken, refill on a new beat
            if (take)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= out_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.frame_done     = out_reg.frame_done;
    assign result.frame_status   = out_reg.frame_status;
    assign result.function_code  = out_reg.function_code;
    assign result.payload_length = out_reg.payload_length;
    assign result.link_ok        = out_reg.link_ok;
    assign result.good_frames    = out_reg.good_frames;

endmodule

>>> tb/fixed_frame_crc8_receiver_tb.sv
// Testbench for fixed_frame_crc8_receiver: drives bytes and link checks over the item
// channel and checks every result beat against a frame tracker kept in step with the block.
// Depends on fcr_pkg, fcr_item_if / fcr_result_if and the receiver RTL.
module fixed_frame_crc8_receiver_tb;
    import fcr_pkg::*;

    localparam int RANDOM_ITEMS   = 1250;
    localparam int PHASE_ITEMS    = 240;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {
        FLAW_NONE,
        FLAW_START,
        FLAW_HEADER,
        FLAW_TYPE,
        FLAW_CRC,
        FLAW_HDR_CRC
    } frame_flaw_t;

    // Tracks frame position, CRC, latches and good-frame count; holds the results due.
    class frame_tracker;
        logic [15:0]      min_good;
        logic [POS_W-1:0] pos;
        logic [7:0]       crc;
        bit               hdr_ok;
        logic [15:0]      func_latch;
        logic [15:0]      size_latch;
        logic [15:0]      good_cnt;
        result_t          results_due[$];
        int               errors;

        function new();
            min_good   = 16'd1;
            pos        = POS_START;
            crc        = 8'h00;
            hdr_ok     = 1'b1;
            func_latch = 16'h0000;
            size_latch = 16'h0000;
            good_cnt   = 16'h0000;
            errors     = 0;
        endfunction

        // Shift the byte in MSB first, one bit per step
        static function logic [7:0] crc_next(logic [7:0] c, logic [7:0] b);
            logic fb;
            for (int i = 7; i >= 0; i--) begin
                fb = c[7] ^ b[i];
                c  = {c[6:0], 1'b0};
                if (fb)
                    c = c ^ 8'hD5;
            end
            return c;
        endfunction

        function void set_min(logic [15:0] v);
            min_good = v;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        function void note_item(opcode_t op, logic [7:0] b);
            result_t r;
            r = '0;
            if (op == OP_LINK_CHECK) begin
                // report the count before the clear; frame state untouched
                r.good_frames = good_cnt;
                if (good_cnt >= min_good) begin
                    r.link_ok = 1'b1;
                    good_cnt  = 16'h0000;
                end
            end
            else begin
                if (pos == POS_START) begin
                    hdr_ok = (b == START_CHAR);
                    crc    = 8'h00;
                end
                else if (pos == POS_HEADER && b != HEADER_CHAR)
                    hdr_ok = 1'b0;
                if (pos == POS_TYPE && b != TYPE_CHAR)
                    hdr_ok = 1'b0;
                case (pos)
                    POS_FUNC_L: func_latch[7:0]  = b;
                    POS_FUNC_H: func_latch[15:8] = b;
                    POS_SIZE_L: size_latch[7:0]  = b;
                    POS_SIZE_H: size_latch[15:8] = b;
                    default: ;
                endcase
                if (pos >= POS_CRC) begin
                    r.frame_done = 1'b1;
                    if (!hdr_ok)
                        r.frame_status = ST_BAD_HDR;
                    else if (crc != b)
                        r.frame_status = ST_BAD_CRC;
                    else
                        r.frame_status = ST_VALID;
                    if (r.frame_status == ST_VALID && good_cnt != 16'hFFFF)
                        good_cnt++;
                    r.function_code  = func_latch;
                    r.payload_length = size_latch;
                    pos = POS_START;
                end
                else begin
                    if (pos >= POS_TYPE)
                        crc = crc_next(crc, b);
                    pos++;
                end
                r.good_frames = good_cnt;
            end
            results_due.push_back(r);
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %h actual %h", $time, field, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t: result beat expected none actual %h", $time, got);
                return;
            end
            want = results_due.pop_front();
            compare("frame_done", 16'(want.frame_done), 16'(got.frame_done));
            compare("frame_status", 16'(want.frame_status), 16'(got.frame_status));
            compare("function_code", want.function_code, got.function_code);
            compare("payload_length", want.payload_length, got.payload_length);
            compare("link_ok", 16'(want.link_ok), 16'(got.link_ok));
            compare("good_frames", want.good_frames, got.good_frames);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    fcr_item_if   item_ch ();
    fcr_result_if result_ch ();

    frame_tracker tracker = new();
    int           items_sent = 0;
    bit           src_steady = 1'b0;
    int           stalled_cycles = 0;

    fixed_frame_crc8_receiver u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .result      (result_ch)
    );

    always #4 clk = ~clk;

    task automatic send_item(input opcode_t op, input logic [7:0] b);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.opcode  <= op;
        item_ch.rx_byte <= b;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        tracker.note_item(op, b);
        items_sent++;
    endtask

    // Hold the sender until every result due has come back
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_min(input logic [15:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        tracker.set_min(v);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_frame(input frame_flaw_t flaw, input logic [15:0] func,
                              input logic [15:0] size);
        logic [7:0] frame [0:CRC_POS];
        logic [7:0] crc;
        int         which;
        src_steady = ($urandom_range(0, 3) == 0);
        frame[0] = START_CHAR;
        frame[1] = HEADER_CHAR;
        frame[2] = TYPE_CHAR;
        frame[3] = 8'($urandom);
        frame[4] = func[7:0];
        frame[5] = func[15:8];
        frame[6] = size[7:0];
        frame[7] = size[15:8];
        for (int i = 8; i < CRC_POS; i++)
            frame[i] = 8'($urandom);
        which = (flaw == FLAW_HDR_CRC) ? $urandom_range(0, 2) : -1;
        if (flaw == FLAW_START || which == 0)
            frame[0] = START_CHAR ^ 8'($urandom_range(1, 255));
        if (flaw == FLAW_HEADER || which == 1)
            frame[1] = HEADER_CHAR ^ 8'($urandom_range(1, 255));
        if (flaw == FLAW_TYPE || which == 2)
            frame[2] = TYPE_CHAR ^ 8'($urandom_range(1, 255));
        crc = 8'h00;
        for (int i = 2; i < CRC_POS; i++)
            crc = frame_tracker::crc_next(crc, frame[i]);
        frame[CRC_POS] = crc;
        if (flaw == FLAW_CRC || flaw == FLAW_HDR_CRC)
            frame[CRC_POS] = crc ^ 8'($urandom_range(1, 255));
        for (int i = 0; i <= CRC_POS; i++) begin
            // a link check inside a frame must not disturb it
            if ($urandom_range(0, 39) == 0)
                send_item(OP_LINK_CHECK, 8'($urandom));
            send_item(OP_RX_BYTE, frame[i]);
        end
    endtask

    // Send raw bytes and link checks, then pad out to a frame boundary
    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++)
            send_item(($urandom_range(0, 9) == 0) ? OP_LINK_CHECK : OP_RX_BYTE,
                      8'($urandom));
        while (tracker.pos != POS_START)
            send_item(OP_RX_BYTE, 8'($urandom));
    endtask

    initial begin : result_sink
        int      stall;
        int      steady_left;
        result_t got;
        steady_left = 0;
        result_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (steady_left > 0) begin
                steady_left--;
                stall = 0;
            end
            else begin
                stall = $urandom_range(0, 16);
                if ($urandom_range(0, 49) == 0)
                    steady_left = $urandom_range(20, 120);
            end
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            got.frame_done     = result_ch.frame_done;
            got.frame_status   = result_ch.frame_status;
            got.function_code  = result_ch.function_code;
            got.payload_length = result_ch.payload_length;
            got.link_ok        = result_ch.link_ok;
            got.good_frames    = result_ch.good_frames;
            tracker.check_result(got);
        end
    end

    always @(posedge clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles", $time, stalled_cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int          base;
        int          phase_start;
        int          phase;
        int          act;
        logic [15:0] min_val;
        item_ch.valid   <= 1'b0;
        item_ch.opcode  <= OP_RX_BYTE;
        item_ch.rx_byte <= 8'h00;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= 16'h0000;
        rst_n           <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: link check at reset minimum, field extremes, combined flaws
        send_item(OP_LINK_CHECK, 8'hFF);
        send_frame(FLAW_NONE, 16'h0000, 16'hFFFF);
        send_item(OP_LINK_CHECK, 8'h00);
        send_frame(FLAW_HDR_CRC, 16'hFFFF, 16'h0000);
        send_frame(FLAW_CRC, 16'hA55A, 16'h5AA5);
        write_min(16'd0);
        send_item(OP_LINK_CHECK, 8'h00);

        base  = items_sent;
        phase = 0;
        while (items_sent - base < RANDOM_ITEMS) begin
            case (phase % 6)
                0: min_val = 16'hFFFF;
                1: min_val = 16'd0;
                2: min_val = 16'd2;
                3: min_val = 16'd3;
                4: min_val = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 5));
                default: min_val = 16'd1;
            endcase
            write_min(min_val);
            phase++;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS &&
                   items_sent - base < RANDOM_ITEMS) begin
                act = $urandom_range(0, 99);
                if (act < 60)
                    send_frame(FLAW_NONE, ($urandom_range(0, 7) == 0) ? 16'hFFFF
                               : 16'($urandom), 16'($urandom));
                else if (act < 75)
                    send_frame(frame_flaw_t'($urandom_range(1, 5)), 16'($urandom),
                               16'($urandom));
                else if (act < 87)
                    send_item(OP_LINK_CHECK, 8'($urandom));
                else if (act < 94)
                    send_noise($urandom_range(1, 50));
                else if (act < 98)
                    repeat ($urandom_range(2, 6)) send_item(OP_LINK_CHECK, 8'($urandom));
                else
                    wait_idle();
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
